// ===== design/button_debounce_press_classifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Button debounce press classifier assertion macros
// Shared assertion wrappers for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Concurrent assertion that is disabled while the asynchronous reset is low.
`define BDPC_ASSERT_RST(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define BDPC_ASSERT_CLK(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bdpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier package
// Widths, register indexes, reset values, shared types and a saturating increment.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SHORT_MAX = 2'd1;
	localparam logic [IDX_W-1:0] REG_LONG      = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1000;
	localparam logic [CFG_W-1:0] LONG_RST      = 16'd3000;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] short_max_ms;
		logic [CFG_W-1:0] long_ms;
	} cfg_t;

	typedef struct packed {
		logic pressed;
		logic released;
		logic short_press;
		logic long_press;
	} event_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ===== design/bdpc_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier sample channel
// Carries one raw pin sample per beat.
// ----------------------------------------------------------------------------
interface bdpc_sample_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

// ===== design/bdpc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier result channel
// Carries the event flags of one tick per beat.
// ----------------------------------------------------------------------------
interface bdpc_result_if;
	logic valid;
	logic ready;
	logic pressed;
	logic released;
	logic short_press;
	logic long_press;

	modport source (output valid, output pressed, output released,
		output short_press, output long_press, input ready);
	modport sink (input valid, input pressed, input released,
		input short_press, input long_press, output ready);
	modport monitor (input valid, input ready, input pressed, input released,
		input short_press, input long_press);
endinterface

// ===== design/bdpc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier configuration registers
// Holds the debounce, short press and long press times.
// ----------------------------------------------------------------------------
module bdpc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [bdpc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]  cfg_data,
	output bdpc_pkg::cfg_t              cfg
);

	bdpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= bdpc_pkg::DEBOUNCE_RST;
			cfg_q.short_max_ms <= bdpc_pkg::SHORT_MAX_RST;
			cfg_q.long_ms      <= bdpc_pkg::LONG_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				bdpc_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_data;
				end
				bdpc_pkg::REG_SHORT_MAX: begin
					cfg_q.short_max_ms <= cfg_data;
				end
				bdpc_pkg::REG_LONG: begin
					cfg_q.long_ms <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/bdpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier core
// Settle and hold timers, accepted level and event decode for one tick.
// ----------------------------------------------------------------------------
module bdpc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           pin_level,
	input  bdpc_pkg::cfg_t cfg,
	output bdpc_pkg::event_t events
);

	logic                       raw_q;
	logic                       settling_q;
	logic [bdpc_pkg::CNT_W-1:0] settle_cnt_q;
	logic                       stable_q;
	logic                       held_q;
	logic [bdpc_pkg::CNT_W-1:0] held_cnt_q;

	logic                       raw_d;
	logic                       settling_d;
	logic [bdpc_pkg::CNT_W-1:0] settle_cnt_d;
	logic                       stable_d;
	logic                       held_d;
	logic [bdpc_pkg::CNT_W-1:0] held_cnt_d;
	logic                       level;
	bdpc_pkg::event_t           ev;

	always_comb begin
		ev           = '0;
		raw_d        = raw_q;
		settling_d   = settling_q;
		settle_cnt_d = settle_cnt_q;
		held_d       = held_q;
		held_cnt_d   = held_cnt_q;

		if (!stable_q) begin
			held_cnt_d = bdpc_pkg::sat_inc(held_cnt_q);
		end

		if (pin_level != raw_q) begin
			raw_d        = pin_level;
			settling_d   = 1'b1;
			settle_cnt_d = '0;
		end else if (settling_q) begin
			settle_cnt_d = bdpc_pkg::sat_inc(settle_cnt_q);
		end

		level = stable_q;
		if (settling_d && (settle_cnt_d >= cfg.debounce_ms)) begin
			level      = raw_d;
			settling_d = 1'b0;
		end

		stable_d = level;
		if (level != stable_q) begin
			if (!level) begin
				ev.pressed = 1'b1;
				held_d     = 1'b1;
				held_cnt_d = '0;
			end else begin
				held_d         = 1'b0;
				ev.short_press = (held_cnt_d <= cfg.short_max_ms);
				ev.released    = 1'b1;
			end
		end

		if (held_d && (held_cnt_d >= cfg.long_ms)) begin
			ev.long_press = 1'b1;
			held_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q        <= 1'b1;
			settling_q   <= 1'b0;
			settle_cnt_q <= '0;
			stable_q     <= 1'b1;
			held_q       <= 1'b0;
			held_cnt_q   <= '0;
		end else if (advance) begin
			raw_q        <= raw_d;
			settling_q   <= settling_d;
			settle_cnt_q <= settle_cnt_d;
			stable_q     <= stable_d;
			held_q       <= held_d;
			held_cnt_q   <= held_cnt_d;
		end
	end

	assign events = ev;

endmodule

// ===== design/button_debounce_press_classifier_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted sample beat goes to the input register, its result beat to the
// result register. Throughput: one sample beat per cycle unless result.ready stalls;
// the timers and the event decode of a tick are combinational between the registers.
// Reset: the timers clear, both levels go to released and the configuration
// registers take their default times; the block is ready at once.
// ----------------------------------------------------------------------------
// Button debounce press classifier
// Debounces a raw active-low button sample per tick and reports press,
// release, short press and long press events.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	bdpc_sample_if.sink                sample,
	bdpc_result_if.source              result,
	input  logic                       cfg_write,
	input  logic [bdpc_pkg::IDX_W-1:0] cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0] cfg_data
);

	bdpc_pkg::cfg_t   cfg;
	bdpc_pkg::event_t events;
	bdpc_pkg::event_t events_s2;
	logic             valid_s1;
	logic             pin_s1;
	logic             valid_s2;
	logic             advance;
	logic             s2_free;

	assign s2_free      = !valid_s2 || result.ready;
	assign advance      = valid_s1 && s2_free;
	assign sample.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			pin_s1 <= sample.pin_level;
		end
	end

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.events    (events)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			events_s2 <= events;
		end
	end

	assign result.valid       = valid_s2;
	assign result.pressed     = events_s2.pressed;
	assign result.released    = events_s2.released;
	assign result.short_press = events_s2.short_press;
	assign result.long_press  = events_s2.long_press;

endmodule

// ===== design/bdpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press classifier checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_unit_macros.svh"

module bdpc_checker (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic pressed,
	input logic released,
	input logic short_press,
	input logic long_press
);

	logic [3:0] flags;

	assign flags = {pressed, released, short_press, long_press};

	// A tick cannot both press and release the accepted level.
	`BDPC_ASSERT_RST(a_press_xor_release, clk, arst_n, valid |-> !(pressed && released), "press and release")

	// A short press is only ever reported together with its release.
	`BDPC_ASSERT_RST(a_short_needs_release, clk, arst_n, (valid && short_press) |-> released, "lone short")

	// A release ends the hold, so no long press can come with it.
	`BDPC_ASSERT_RST(a_no_long_on_release, clk, arst_n, valid |-> !(released && long_press), "long on release")

	// A stalled result beat holds its flags.
	`BDPC_ASSERT_RST(a_stall_hold, clk, arst_n, (valid && !ready) |=> (valid && $stable(flags)), "stall changed")

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.pressed     (result.pressed),
	.released    (result.released),
	.short_press (result.short_press),
	.long_press  (result.long_press)
);
